// ===== rtl/slxp_pkg.sv =====
// Shared types and constants for the sync/length/XOR packet parser.
// No dependencies; imported by every module of the block.
package slxp_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_VALUE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OPCODE_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH   = 2'd2;

  // Register values after reset
  localparam logic [7:0] SYNC_VALUE_RST   = 8'h55;
  localparam logic [7:0] OPCODE_COUNT_RST = 8'd16;
  localparam logic [6:0] MAX_LENGTH_RST   = 7'd64;

  // Largest length the 6-bit payload index can address
  localparam int INDEX_CAP = 64;

  typedef enum logic [2:0] {
    ST_ONGOING      = 3'd0,
    ST_READY        = 3'd1,
    ST_BAD_OPCODE   = 3'd2,
    ST_BAD_LENGTH   = 3'd3,
    ST_BAD_CHECKSUM = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] opcode_count;
    logic [6:0] max_length;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] packet_opcode;
    logic [6:0] packet_length;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
  } result_t;

endpackage

// ===== rtl/slxp_cfg.sv =====
// Configuration register file: sync value, opcode count, max length.
// Depends on slxp_pkg.
module slxp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [slxp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [slxp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output slxp_pkg::cfg_t                  cfg
);
  import slxp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value   <= SYNC_VALUE_RST;
      cfg.opcode_count <= OPCODE_COUNT_RST;
      cfg.max_length   <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      // writes to unused indexes are dropped
      unique case (cfg_addr)
        REG_SYNC_VALUE:   cfg.sync_value   <= cfg_wdata;
        REG_OPCODE_COUNT: cfg.opcode_count <= cfg_wdata;
        REG_MAX_LENGTH:   cfg.max_length   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/slxp_parser.sv =====
// Input register, parse state machine and result register.
// Depends on slxp_pkg; configuration comes from slxp_cfg.
module slxp_parser #(
  parameter int MAX_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  slxp_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output slxp_pkg::result_t out_result
);
  import slxp_pkg::*;

  localparam int         CAP   = (MAX_LEN < INDEX_CAP) ? MAX_LEN : INDEX_CAP;
  localparam logic [6:0] CAP_W = 7'(CAP);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_OPCODE = 3'd1,
    PH_LENGTH = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       advance;

  phase_t     phase, phase_next;
  logic [7:0] opcode_held, opcode_held_next;
  logic [6:0] length_held, length_held_next;
  logic [5:0] byte_count, byte_count_next;
  logic [7:0] running_xor, running_xor_next;
  result_t    result_next;

  logic [6:0] length_limit;
  logic [6:0] count_inc;

  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  assign length_limit = (cfg.max_length < CAP_W) ? cfg.max_length : CAP_W;
  assign count_inc    = {1'b0, byte_count} + 7'd1;

  always_comb begin
    phase_next       = phase;
    opcode_held_next = opcode_held;
    length_held_next = length_held;
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    result_next      = '0;
    result_next.status = ST_ONGOING;
    unique case (phase)
      PH_OPCODE: begin
        if (byte_q >= cfg.opcode_count) begin
          phase_next         = PH_HUNT;
          result_next.status = ST_BAD_OPCODE;
        end else begin
          opcode_held_next = byte_q;
          running_xor_next = running_xor ^ byte_q;
          phase_next       = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (byte_q > {1'b0, length_limit}) begin
          phase_next         = PH_HUNT;
          result_next.status = ST_BAD_LENGTH;
        end else begin
          length_held_next = byte_q[6:0];
          running_xor_next = running_xor ^ byte_q;
          // zero length skips straight to the checksum
          phase_next       = (byte_q == 8'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        running_xor_next          = running_xor ^ byte_q;
        result_next.payload_valid = 1'b1;
        result_next.payload_byte  = byte_q;
        result_next.payload_index = byte_count;
        if (count_inc >= length_held) begin
          phase_next = PH_CHECK;
        end else begin
          byte_count_next = count_inc[5:0];
        end
      end
      PH_CHECK: begin
        result_next.status = (byte_q == running_xor) ? ST_READY : ST_BAD_CHECKSUM;
        phase_next         = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
        if (byte_q == cfg.sync_value) begin
          opcode_held_next = '0;
          length_held_next = '0;
          byte_count_next  = '0;
          running_xor_next = cfg.sync_value;
          phase_next       = PH_OPCODE;
        end
      end
    endcase
    result_next.packet_opcode = opcode_held_next;
    result_next.packet_length = length_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid  <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_HUNT;
      opcode_held <= '0;
      length_held <= '0;
      byte_count  <= '0;
      running_xor <= '0;
    end else begin
      if (in_ready) begin
        byte_valid <= in_valid;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        phase       <= phase_next;
        opcode_held <= opcode_held_next;
        length_held <= length_held_next;
        byte_count  <= byte_count_next;
        running_xor <= running_xor_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
    if (advance) begin
      out_result <= result_next;
    end
  end

  a_payload_is_ongoing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.payload_valid |-> out_result.status == ST_ONGOING)
    else $error("payload byte reported with a final status");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> {1'b0, byte_count} < length_held)
    else $error("payload count reached held length while in data phase");

  a_length_capped: assert property (@(posedge clk) disable iff (rst)
    length_held <= CAP_W)
    else $error("held length above the length cap");

  a_held_byte_stable: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !advance |=> byte_valid && $stable(byte_q))
    else $error("stalled input byte lost or changed");

  a_sync_loads_xor: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_HUNT && byte_q == cfg.sync_value
      |=> phase == PH_OPCODE && running_xor == $past(cfg.sync_value))
    else $error("sync byte did not start a packet");

endmodule

// ===== rtl/sync_length_xor_packet_parser.sv =====
// Top level of the sync-byte, length-prefixed packet parser with XOR checksum.
// Depends on slxp_pkg, slxp_cfg and slxp_parser.
//
//   channel   dir  payload
//   s_axis_*  in   tdata[7:0] = rx_byte
//   m_axis_*  out  tdata[31:0] = status, packet_opcode, packet_length,
//                  payload_byte, payload_index; tuser = payload_valid
//   cfg_*     in   write enable, register index, write data
//
// One item per cycle while the output is not stalled; each item passes the input register, then the result register.
// The only loop is the parse state update.
// Synchronous reset returns to hunting and restores the register defaults.
// A stalled result holds the output register; one more item waits in the input
// register, after which s_axis_tready drops.
module sync_length_xor_packet_parser #(
  parameter int MAX_LEN = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] status, [10:3] packet_opcode, [17:11] packet_length,
  // [25:18] payload_byte, [31:26] payload_index
  output logic [31:0]                     m_axis_tdata,
  output logic                            m_axis_tuser,  // [0] payload_valid
  input  logic                            cfg_we,
  input  logic [slxp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [slxp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import slxp_pkg::*;

  cfg_t    cfg;
  result_t result;

  slxp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slxp_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  assign m_axis_tdata = {result.payload_index, result.payload_byte,
                         result.packet_length, result.packet_opcode, result.status};
  assign m_axis_tuser = result.payload_valid;

endmodule
